/* rtl/core/cc8ks_pkg.sv */
// ----------------------------------------------------------------------------
// cc8ks_pkg
// Shared constants, codes and helpers for the ChaCha8 keystream XOR block.
// ----------------------------------------------------------------------------
package cc8ks_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 4;

  localparam logic [31:0] TAU0 = 32'h6170_7865;
  localparam logic [31:0] TAU1 = 32'h3120_646e;
  localparam logic [31:0] TAU2 = 32'h7962_2d36;
  localparam logic [31:0] TAU3 = 32'h6b20_6574;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_NONCE    = 2'd2;

  localparam logic OP_XOR  = 1'b0;
  localparam logic OP_SKIP = 1'b1;

  typedef struct packed {
    logic start;
    logic consume;
  } cc8ks_ctrl_t;

  function automatic logic [31:0] init_word(input logic [3:0] idx,
                                            input logic [63:0] key_low,
                                            input logic [63:0] key_high,
                                            input logic [63:0] ctr,
                                            input logic [63:0] nonce);
    logic [31:0] word;
    case (idx)
      4'd0: word = TAU0;
      4'd1: word = TAU1;
      4'd2: word = TAU2;
      4'd3: word = TAU3;
      4'd4, 4'd8: word = key_low[31:0];
      4'd5, 4'd9: word = key_low[63:32];
      4'd6, 4'd10: word = key_high[31:0];
      4'd7, 4'd11: word = key_high[63:32];
      4'd12: word = ctr[31:0];
      4'd13: word = ctr[63:32];
      4'd14: word = nonce[31:0];
      default: word = nonce[63:32];
    endcase
    return word;
  endfunction

endpackage

/* rtl/core/cc8ks_core.sv */
// ----------------------------------------------------------------------------
// cc8ks_core
// Block generator: one add-xor-rotate unit steps through the quarter rounds on
// column 0 of a rotating 4x4 state, then adds the initial state back.
// ----------------------------------------------------------------------------
module cc8ks_core
  import cc8ks_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cc8ks_ctrl_t ctrl,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [63:0] ctr,
  input  logic [63:0] nonce,
  output logic        done,
  output logic [63:0] ks_pair
);

  localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DrW-1:0] DrLast = DrW'(DOUBLE_ROUNDS - 1);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_FEED  = 2'd2;

  logic [1:0]     phase;
  logic [1:0]     step;
  logic [2:0]     qr;
  logic [DrW-1:0] dr;
  logic [3:0]     ff_idx;
  logic [31:0]    w [16];

  logic [31:0] sum_a;
  logic [31:0] sum_b;
  logic [31:0] sum;
  logic [31:0] mix;
  logic [31:0] rot;
  logic [31:0] tmp [16];
  logic [31:0] w_step [16];

  assign sum_a = (phase == C_FEED || !step[0]) ? w[0] : w[8];
  assign sum_b = (phase == C_FEED) ? init_word(ff_idx, key_low, key_high, ctr, nonce)
                                   : (step[0] ? w[12] : w[4]);
  assign sum   = sum_a + sum_b;
  assign mix   = (step[0] ? w[4] : w[12]) ^ sum;

  always_comb begin
    case (step)
      2'd0: rot = {mix[15:0], mix[31:16]};
      2'd1: rot = {mix[19:0], mix[31:20]};
      2'd2: rot = {mix[23:0], mix[31:24]};
      default: rot = {mix[24:0], mix[31:25]};
    endcase
  end

  always_comb begin
    logic [1:0] k;
    for (int i = 0; i < 16; i++) begin
      tmp[i] = w[i];
    end
    if (step[0]) begin
      tmp[8] = sum;
      tmp[4] = rot;
    end else begin
      tmp[0]  = sum;
      tmp[12] = rot;
    end
    for (int r = 0; r < 4; r++) begin
      if (qr[1:0] == 2'd3) begin
        k = qr[2] ? 2'(1 - r) : 2'(1 + r);
      end else begin
        k = 2'd1;
      end
      for (int c = 0; c < 4; c++) begin
        if (step == 2'd3) begin
          w_step[4*r + c] = tmp[4*r + ((c + int'(k)) % 4)];
        end else begin
          w_step[4*r + c] = tmp[4*r + c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= C_IDLE;
      step   <= 2'd0;
      qr     <= 3'd0;
      dr     <= '0;
      ff_idx <= 4'd0;
    end else begin
      case (phase)
        C_IDLE: begin
          if (ctrl.start) begin
            phase <= C_ROUND;
            step  <= 2'd0;
            qr    <= 3'd0;
            dr    <= '0;
          end
        end
        C_ROUND: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            qr <= qr + 3'd1;
            if (qr == 3'd7) begin
              dr <= dr + 1'b1;
              if (dr == DrLast) begin
                phase  <= C_FEED;
                ff_idx <= 4'd0;
              end
            end
          end
        end
        C_FEED: begin
          ff_idx <= ff_idx + 4'd1;
          if (ff_idx == 4'd15) begin
            phase <= C_IDLE;
          end
        end
        default: phase <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      C_ROUND: begin
        for (int i = 0; i < 16; i++) begin
          w[i] <= w_step[i];
        end
      end
      C_FEED: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= sum;
      end
      default: begin
        if (ctrl.start) begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= init_word(4'(i), key_low, key_high, ctr, nonce);
          end
        end else if (ctrl.consume) begin
          for (int i = 0; i < 14; i++) begin
            w[i] <= w[i+2];
          end
        end
      end
    endcase
  end

  assign done    = (phase == C_FEED) && (ff_idx == 4'd15);
  assign ks_pair = {w[1], w[0]};

endmodule

/* rtl/core/chacha8_keystream_xor.sv */
// ----------------------------------------------------------------------------
// chacha8_keystream_xor
// XORs 8-byte data items with a ChaCha8 keystream (128-bit key, 64-bit
// counter, 64-bit nonce); skip items advance the block counter.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser selects XOR or skip, tlast ends
// a message. Each XOR item yields one result item on the m_ stream; a skip
// item yields none. Key and nonce are written through the APB port, and any
// write to them restarts the counter at zero and drops the current block.
// A keystream block is made by one shared add-xor-rotate unit, one quarter
// round step per cycle, followed by the feed-forward add on the same adder.
// An XOR item whose block is ready goes to the emit state when accepted, and
// its result is registered into the output register from there; an item that
// needs a new block first waits in the generate state until the core is done.
// The block takes one item at a time and is not ready while it works on it.
// A skip item is absorbed on acceptance. When the receiver stalls, the result
// waits in the output register; a further item may still be accepted, but
// its result is held back until the register is free.
// After reset key, nonce and counter are zero and no block is ready.
// ----------------------------------------------------------------------------
module chacha8_keystream_xor
  import cc8ks_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // data_chunk [63:0], amount [95:64]
  input  logic        s_tuser,  // opcode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // result_chunk [63:0], valid_bytes [67:64], zero
  output logic        m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  state;
  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [63:0] nonce;
  logic [63:0] ctr;
  logic [2:0]  pos;
  logic        blk_ready;

  logic [63:0] in_data;
  logic [3:0]  in_count;
  logic        in_last;
  logic [63:0] out_chunk;
  logic [3:0]  out_count;
  logic        out_last;

  logic        cfg_wr;
  logic [1:0]  reg_sel;
  logic        s_acc;
  logic        emit_go;
  logic [31:0] amount;
  logic [3:0]  count;
  logic [63:0] ctr_sum;
  logic [63:0] mask;
  logic [63:0] ks_pair;
  logic        gen_done;
  cc8ks_ctrl_t core_ctrl;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign reg_sel  = paddr[4:3];
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid & s_tready;
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign amount   = s_tdata[95:64];

  // A count of zero or above eight means a full chunk.
  assign count = ((amount == 32'd0) || (|amount[31:4]) || (amount[3] && |amount[2:0]))
                 ? 4'd8 : amount[3:0];

  assign ctr_sum = ctr + ((state == ST_GEN) ? 64'd1 : {32'd0, amount});

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{4'(i) < in_count}};
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      REG_NONCE:    prdata = nonce;
      default:      prdata = 64'd0;
    endcase
  end

  assign core_ctrl.start   = s_acc && (s_tuser == OP_XOR) && !blk_ready;
  assign core_ctrl.consume = emit_go;

  cc8ks_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (core_ctrl),
    .key_low (key_low),
    .key_high(key_high),
    .ctr     (ctr),
    .nonce   (nonce),
    .done    (gen_done),
    .ks_pair (ks_pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_low   <= 64'd0;
      key_high  <= 64'd0;
      nonce     <= 64'd0;
      ctr       <= 64'd0;
      pos       <= 3'd0;
      blk_ready <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser == OP_SKIP) begin
              ctr       <= ctr_sum;
              pos       <= 3'd0;
              blk_ready <= 1'b0;
            end else begin
              state <= blk_ready ? ST_EMIT : ST_GEN;
            end
          end
        end
        ST_GEN: begin
          if (gen_done) begin
            ctr       <= ctr_sum;
            blk_ready <= 1'b1;
            pos       <= 3'd0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= ST_IDLE;
            if (in_last || pos == 3'd7) begin
              pos       <= 3'd0;
              blk_ready <= 1'b0;
            end else begin
              pos <= pos + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        case (reg_sel)
          REG_KEY_LOW: begin
            key_low   <= pwdata;
            ctr       <= 64'd0;
            pos       <= 3'd0;
            blk_ready <= 1'b0;
          end
          REG_KEY_HIGH: begin
            key_high  <= pwdata;
            ctr       <= 64'd0;
            pos       <= 3'd0;
            blk_ready <= 1'b0;
          end
          REG_NONCE: begin
            nonce     <= pwdata;
            ctr       <= 64'd0;
            pos       <= 3'd0;
            blk_ready <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_data  <= s_tdata[63:0];
      in_count <= count;
      in_last  <= s_tlast;
    end
    if (emit_go) begin
      out_chunk <= in_data ^ (ks_pair & mask);
      out_count <= in_count;
      out_last  <= in_last;
    end
  end

  assign m_tdata = {4'd0, out_count, out_chunk};
  assign m_tlast = out_last;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// ChaCha8 keystream XOR testbench
// Drives XOR and skip items into the block under random back-pressure on
// both streams, off in two phases. A self-contained ChaCha8 model predicts
// each result item, checked field by field against the oldest prediction.
// Key and nonce are written over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
  import cc8ks_pkg::*;

  localparam int BLOCK_CYCLES = 32 * DOUBLE_ROUNDS_DEF + 16;
  localparam int SETTLE_CYCLES = BLOCK_CYCLES + 16;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [63:0] data;
    logic [31:0] amount;
    logic        eoc;
  } stream_item_t;

  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } cipher_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;

  stream_item_t   pending_items[$];
  cipher_result_t expected_results[$];
  stream_item_t   cur_item;
  int             error_count = 0;
  int             idle_odds = 0;
  int             send_gap = 0;
  int             recv_gap = 0;

  logic [63:0]       key_lo = '0;
  logic [63:0]       key_hi = '0;
  logic [63:0]       iv = '0;
  logic [63:0]       blk_ctr = '0;
  logic [15:0][31:0] ks_words = '0;
  int                slot = 0;
  logic              have_block = 1'b0;

  chacha8_keystream_xor DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [15:0][31:0] qround(input logic [15:0][31:0] s,
                                               input int a, input int b,
                                               input int c, input int d);
    logic [15:0][31:0] x;
    x = s;
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
    return x;
  endfunction

  function automatic logic [15:0][31:0] chacha_block(input logic [63:0] kl,
                                                     input logic [63:0] kh,
                                                     input logic [63:0] ctr,
                                                     input logic [63:0] nc);
    logic [15:0][31:0] init_st;
    logic [15:0][31:0] w;
    init_st[0] = TAU0;
    init_st[1] = TAU1;
    init_st[2] = TAU2;
    init_st[3] = TAU3;
    init_st[4] = kl[31:0];
    init_st[5] = kl[63:32];
    init_st[6] = kh[31:0];
    init_st[7] = kh[63:32];
    init_st[8] = kl[31:0];
    init_st[9] = kl[63:32];
    init_st[10] = kh[31:0];
    init_st[11] = kh[63:32];
    init_st[12] = ctr[31:0];
    init_st[13] = ctr[63:32];
    init_st[14] = nc[31:0];
    init_st[15] = nc[63:32];
    w = init_st;
    for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
      w = qround(w, 0, 4, 8, 12);
      w = qround(w, 1, 5, 9, 13);
      w = qround(w, 2, 6, 10, 14);
      w = qround(w, 3, 7, 11, 15);
      w = qround(w, 0, 5, 10, 15);
      w = qround(w, 1, 6, 11, 12);
      w = qround(w, 2, 7, 8, 13);
      w = qround(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + init_st[i];
    return w;
  endfunction

  task automatic cipher_step(input stream_item_t it);
    logic [3:0]     cnt;
    logic [63:0]    ks;
    logic [63:0]    mask;
    cipher_result_t res;
    if (it.opcode == OP_SKIP) begin
      blk_ctr = blk_ctr + {32'd0, it.amount};
      slot = 0;
      have_block = 1'b0;
    end else begin
      cnt = (it.amount == 0 || it.amount > 8) ? 4'd8 : it.amount[3:0];
      if (!have_block) begin
        ks_words = chacha_block(key_lo, key_hi, blk_ctr, iv);
        blk_ctr = blk_ctr + 64'd1;
        have_block = 1'b1;
        slot = 0;
      end
      ks = {ks_words[2 * slot + 1], ks_words[2 * slot]};
      mask = (cnt == 4'd8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
      res.chunk = it.data ^ (ks & mask);
      res.nbytes = cnt;
      res.last = it.eoc;
      expected_results.push_back(res);
      if (it.eoc || slot == 7) begin
        slot = 0;
        have_block = 1'b0;
      end else begin
        slot = slot + 1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_LOW:  key_lo = value;
      REG_KEY_HIGH: key_hi = value;
      REG_NONCE:    iv = value;
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      blk_ctr = '0;
      slot = 0;
      have_block = 1'b0;
    end
  endtask

  task automatic push_item(input logic op, input logic [63:0] data,
                           input logic [31:0] amount, input logic eoc);
    stream_item_t it;
    it.opcode = op;
    it.data = data;
    it.amount = amount;
    it.eoc = eoc;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_random(input int n);
    int added;
    int len;
    logic [31:0] amt;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 99) < 8) begin
        amt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        push_item(OP_SKIP, {$urandom, $urandom}, amt, 1'($urandom_range(0, 1)));
        added++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int j = 0; j < len && added < n; j++) begin
          amt = (j == len - 1) ? $urandom_range(1, 8) : 8;
          case ($urandom_range(0, 19))
            0: amt = $urandom;
            1: amt = $urandom_range(0, 15);
            2: amt = $urandom_range(1, 7);
            default: ;
          endcase
          push_item(OP_XOR, {$urandom, $urandom}, amt, j == len - 1);
          added++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) cipher_step(cur_item);
      if (s_tvalid && !s_tready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 8);
        s_tvalid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {cur_item.amount, cur_item.data};
        s_tuser <= cur_item.opcode;
        s_tlast <= cur_item.eoc;
      end
    end
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result chunk", m_tdata[63:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[63:0] !== want.chunk)
            report_mismatch("result_chunk", m_tdata[63:0], want.chunk);
          if (m_tdata[67:64] !== want.nbytes)
            report_mismatch("valid_bytes", 64'(m_tdata[67:64]), 64'(want.nbytes));
          if (m_tlast !== want.last)
            report_mismatch("last", 64'(m_tlast), 64'(want.last));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        recv_gap = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset key material: amounts at and beyond the limits, a short item in
    // mid-message, a block used up, skips with ignored fields and a carry.
    idle_odds = 5;
    push_item(OP_XOR, '0, 32'd8, 1'b0);
    push_item(OP_XOR, '1, 32'd0, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd3, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd9, 1'b0);
    push_item(OP_XOR, '1, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd1, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd5, 1'b1);
    push_item(OP_SKIP, '1, 32'd0, 1'b1);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd7, 1'b1);
    push_item(OP_SKIP, '0, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_SKIP, '1, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd2, 1'b0);
    push_item(OP_SKIP, {$urandom, $urandom}, 32'd1, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b1);
    push_item(OP_XOR, '0, 32'd4, 1'b1);
    wait_drained();

    apb_write(REG_KEY_LOW, '1);
    apb_write(REG_KEY_HIGH, '1);
    apb_write(REG_NONCE, '1);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd6, 1'b0);
    wait_drained();

    // A write outside the register map must leave the open block in place.
    apb_write(REG_UNUSED, {$urandom, $urandom});
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b0);
    push_item(OP_XOR, {$urandom, $urandom}, 32'd8, 1'b1);
    wait_drained();

    apb_write(REG_KEY_LOW, '0);
    apb_write(REG_KEY_HIGH, '0);
    apb_write(REG_NONCE, '0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        if ($urandom_range(0, 1)) apb_write(REG_KEY_LOW, pick_value());
        if ($urandom_range(0, 1)) apb_write(REG_KEY_HIGH, pick_value());
        if ($urandom_range(0, 1)) apb_write(REG_NONCE, pick_value());
      end
      case (ph)
        2: idle_odds = 0;
        5: idle_odds = 0;
        default: idle_odds = $urandom_range(3, 8);
      endcase
      queue_random(80);
      do @(negedge clk);
      while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
      queue_random(80);
      wait_drained();
    end

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), '0);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* chacha8_keystream_xor.f */
rtl/core/cc8ks_pkg.sv
rtl/core/cc8ks_core.sv
rtl/core/chacha8_keystream_xor.sv
dv/testbench.sv
